@@ rtl/core/fplog_pkg.sv @@
// Shared constants for the fixed-point log2 polynomial core.
package fplog_pkg;

    localparam int XW        = 32;  // operand, coefficient and result width
    localparam int BPOS_W    = 5;   // leading-one position, 0..30
    localparam int CFG_IDX_W = 8;   // register index width on the config port

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE = CFG_IDX_W'(2);

endpackage

@@ rtl/core/fixed_point_log2_polynomial_core.sv @@
// An accepted operand runs through stages 1 to 4 into the output register.
// One request per cycle unless the output stalls; stages hold alone, bubbles collapse.
// Pipeline: leading-one detect, normalize, f*f and c1*f, c2*f^2 and partial sum, final add.
// Three multipliers: f*f, c1*f and c2*f^2.
// Reset (synchronous, active low) empties the pipeline and clears the coefficients to zero.
module fixed_point_log2_polynomial_core
    import fplog_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [XW-1:0] i_x_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [XW-1:0] o_log_out,
    output logic                 o_bad_operand,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [XW-1:0]        i_cfg_data
);

    localparam int FW = FRAC_BITS + 1;       // mantissa width, value in [1,2)
    localparam int LW = XW + FW + 1;         // c1 * f product width
    localparam int QW = XW + FW + 2;         // c2 * f^2 product width
    localparam logic [BPOS_W-1:0] FB = BPOS_W'(FRAC_BITS);

    // coefficients
    logic signed [XW-1:0] r_coef_const;
    logic signed [XW-1:0] r_coef_linear;
    logic signed [XW-1:0] r_coef_square;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // stage 1: operand, leading-one position, error flag
    logic [XW-1:0]      r_s1_x;
    logic [BPOS_W-1:0]  r_s1_b, n_s1_b;
    logic               r_s1_bad, n_s1_bad;
    // stage 2: mantissa and exponent term
    logic [XW-1:0]      s2_rest, s2_frac;
    logic [FW-1:0]      r_s2_f, n_s2_f;
    logic [XW-1:0]      r_s2_expo, n_s2_expo;
    logic               r_s2_bad;
    // stage 3: products
    logic [2*FW-1:0]    r_s3_pf2, n_s3_pf2;
    logic signed [LW-1:0] r_s3_plin, n_s3_plin;
    logic [XW-1:0]      r_s3_expo;
    logic               r_s3_bad;
    // stage 4: square term product and partial sum
    logic [FW:0]        s4_f2;
    logic signed [QW-1:0] r_s4_psq, n_s4_psq;
    logic [XW-1:0]      r_s4_part, n_s4_part;
    logic               r_s4_bad;
    // output register
    logic [XW-1:0]      r_log, n_log;
    logic               r_bad;

    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready    = en1;
    assign o_out_valid   = r_v5;
    assign o_log_out     = r_log;
    assign o_bad_operand = r_bad;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_const  <= '0;
            r_coef_linear <= '0;
            r_coef_square <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COEF_CONST:  r_coef_const  <= i_cfg_data;
                CFG_COEF_LINEAR: r_coef_linear <= i_cfg_data;
                CFG_COEF_SQUARE: r_coef_square <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: leading one, bit 31 is never set for a good operand
    always_comb begin
        n_s1_b = '0;
        for (int i = 0; i < XW - 1; i++) begin
            if (i_x_in[i]) n_s1_b = BPOS_W'(i);
        end
        n_s1_bad = i_x_in[XW-1] || (i_x_in == '0);
    end

    // stage 2: drop the leading one and align to FRAC_BITS
    always_comb begin
        s2_rest = r_s1_x & ~(XW'(1) << r_s1_b);
        if (r_s1_b > FB) begin
            s2_frac = s2_rest >> (r_s1_b - FB);
        end else begin
            s2_frac = s2_rest << (FB - r_s1_b);
        end
        n_s2_f    = {1'b1, s2_frac[FRAC_BITS-1:0]};
        // (b - FRAC_BITS) << FRAC_BITS, wraps mod 2^32
        n_s2_expo = (XW'(r_s1_b) - XW'(FRAC_BITS)) << FRAC_BITS;
    end

    // stage 3
    assign n_s3_pf2  = r_s2_f * r_s2_f;
    assign n_s3_plin = r_coef_linear * $signed({1'b0, r_s2_f});

    // stage 4: f^2 is never negative, so the truncated product is a plain slice
    assign s4_f2     = r_s3_pf2[2*FW-1:FRAC_BITS];
    assign n_s4_psq  = r_coef_square * $signed({1'b0, s4_f2});
    assign n_s4_part = r_coef_const + r_s3_plin[FRAC_BITS +: XW] + r_s3_expo;

    // stage 5
    assign n_log = r_s4_bad ? '0 : (r_s4_part + r_s4_psq[FRAC_BITS +: XW]);

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_s1_x   <= i_x_in;
            r_s1_b   <= n_s1_b;
            r_s1_bad <= n_s1_bad;
        end
        if (en2 && r_v1) begin
            r_s2_f    <= n_s2_f;
            r_s2_expo <= n_s2_expo;
            r_s2_bad  <= r_s1_bad;
        end
        if (en3 && r_v2) begin
            r_s3_pf2  <= n_s3_pf2;
            r_s3_plin <= n_s3_plin;
            r_s3_expo <= r_s2_expo;
            r_s3_bad  <= r_s2_bad;
        end
        if (en4 && r_v3) begin
            r_s4_psq  <= n_s4_psq;
            r_s4_part <= n_s4_part;
            r_s4_bad  <= r_s3_bad;
        end
        if (en5 && r_v4) begin
            r_log <= n_log;
            r_bad <= r_s4_bad;
        end
    end

`ifndef NO_ASSERTIONS
    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_operand |-> o_log_out == '0)
        else $error("error result carries a nonzero value");

    a_bad_flag_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=>
            r_v1 && (r_s1_bad == ($past(i_x_in[XW-1]) || ($past(i_x_in) == '0))))
        else $error("stage 1 error flag does not match the accepted operand");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_out_ready)
        else $error("input blocked while the pipeline has room");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == CFG_COEF_SQUARE |=>
            r_coef_square == $signed($past(i_cfg_data)))
        else $error("coefficient write lost");
`endif

endmodule

@@ verif/tb_fixed_point_log2_polynomial_core.sv @@
// Self-checking testbench for the fixed-point log2 polynomial core.
`timescale 1ns / 100ps

typedef struct packed {
    logic [31:0] operand;
    logic [31:0] log_value;
    logic        bad;
} log2_expect_t;

class Log2Scoreboard #(int FB = 16);
    logic [31:0]  coef_c;
    logic [31:0]  coef_l;
    logic [31:0]  coef_s;
    log2_expect_t pending_logs[$];
    int           mismatches;

    function new();
        coef_c = '0;
        coef_l = '0;
        coef_s = '0;
        mismatches = 0;
    endfunction

    function void set_coef(logic [7:0] idx, logic [31:0] data);
        case (idx)
            fplog_pkg::CFG_COEF_CONST:  coef_c = data;
            fplog_pkg::CFG_COEF_LINEAR: coef_l = data;
            fplog_pkg::CFG_COEF_SQUARE: coef_s = data;
            default: ;  // unknown index: ignored
        endcase
    endfunction

    // (a*b) >>> FB on the full 64-bit product, low word kept
    function logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        wa = {{32{a[31]}}, a};
        wb = {{32{b[31]}}, b};
        prod = wa * wb;
        prod = prod >>> FB;
        return prod[31:0];
    endfunction

    function void note_request(logic [31:0] x);
        log2_expect_t e;
        logic [31:0]  rest;
        logic [31:0]  f;
        logic [31:0]  f2;
        logic [31:0]  poly;
        logic [31:0]  expo;
        int           b;
        e.operand = x;
        if (x == '0 || x[31]) begin
            e.log_value = '0;
            e.bad = 1'b1;
        end else begin
            b = 30;
            while (b > 0 && !x[b])
                b--;
            rest = x ^ (32'd1 << b);
            if (b > FB)
                f = rest >> (b - FB);
            else
                f = rest << (FB - b);
            f = f + (32'd1 << FB);
            f2 = fx_mul(f, f);
            poly = coef_c + fx_mul(coef_l, f) + fx_mul(coef_s, f2);
            expo = 32'(b - FB) << FB;
            e.log_value = poly + expo;
            e.bad = 1'b0;
        end
        pending_logs.push_back(e);
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("log2 mismatch: %s", msg);
    endfunction

    function void check_result(logic [31:0] log_value, logic bad);
        log2_expect_t e;
        if (pending_logs.size() == 0) begin
            report($sformatf("unexpected result log_out=%h bad_operand=%b", log_value, bad));
            return;
        end
        e = pending_logs.pop_front();
        if (log_value !== e.log_value || bad !== e.bad)
            report($sformatf("x_in=%h expected log_out=%h bad_operand=%b, got log_out=%h bad_operand=%b",
                             e.operand, e.log_value, e.bad, log_value, bad));
    endfunction

    function int pending();
        return pending_logs.size();
    endfunction

    function void close_out();
        while (pending_logs.size() != 0)
            report($sformatf("no result for x_in=%h", pending_logs.pop_front().operand));
    endfunction
endclass

module tb_fixed_point_log2_polynomial_core;
    import fplog_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = 5;
    localparam int STALL_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [XW-1:0] i_x_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [XW-1:0] o_log_out;
    logic                 o_bad_operand;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [XW-1:0]        i_cfg_data;

    Log2Scoreboard #(FRAC_BITS) sb;
    bit quiet;
    int idle_cycles;

    logic [31:0] corner_ops [19] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
        32'h0000_0002, 32'h0000_0003, 32'h0001_0000, 32'h0001_8000, 32'h0001_FFFF,
        32'h0000_8000, 32'h0000_FFFF, 32'h4000_0000, 32'h7FFF_0000, 32'h5555_5555,
        32'h2AAA_AAAA, 32'h0001_0001, 32'hFFFF_0000, 32'h0000_8001
    };

    fixed_point_log2_polynomial_core #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_x_in(i_x_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_log_out(o_log_out),
        .o_bad_operand(o_bad_operand),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Handshakes are sampled at the edge, before any update of this step lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_coef(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_request(i_x_in);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_log_out, o_bad_operand);
        end
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side back-pressure
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    function automatic logic [31:0] rand_operand();
        int          sel;
        int          b;
        logic [31:0] v;
        sel = $urandom_range(0, 19);
        v = $urandom();
        if (sel < 2)
            return v;
        else if (sel == 2)
            return 32'($urandom_range(0, 4));
        else if (sel == 3)
            return v | 32'h8000_0000;
        b = $urandom_range(0, 30);
        return (v & ((32'd1 << b) - 32'd1)) | (32'd1 << b);
    endfunction

    task automatic send_operand(logic [31:0] x, int gap_odds);
        if (!quiet && $urandom_range(1, 100) <= gap_odds) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [XW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Only called with the pipeline empty; also pokes an unused index.
    task automatic load_coefs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
        cfg_write(CFG_COEF_CONST, c0);
        cfg_write(CFG_COEF_LINEAR, c1);
        cfg_write(CFG_COEF_SQUARE, c2);
        cfg_write(($urandom_range(0, 1) == 0) ? CFG_IDX_W'(255)
                                               : CFG_IDX_W'($urandom_range(3, 254)),
                  $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_run(int count, int gap_odds);
        repeat (count) send_operand(rand_operand(), gap_odds);
        drain();
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_x_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients still at reset: result is the exponent term alone
        random_run(40, 25);

        // a usable log2 fit, corners first
        load_coefs(-32'sd110083, 32'sd132357, -32'sd22276);
        foreach (corner_ops[k])
            send_operand(corner_ops[k], 20);
        random_run(70, 30);

        // extreme coefficients force the intermediate sums to wrap
        load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_run(60, 50);
        load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_run(60, 10);
        load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        random_run(40, 25);

        load_coefs($urandom(), $urandom(), $urandom());
        random_run(50, 40);
        load_coefs(32'($urandom_range(0, 262143)) - 32'd131072,
                   32'($urandom_range(0, 262143)) - 32'd131072,
                   32'($urandom_range(0, 262143)) - 32'd131072);
        random_run(50, 25);

        // full-rate tail, no stalls on either side
        quiet = 1'b1;
        load_coefs(-32'sd110083, 32'sd132357, -32'sd22276);
        random_run(60, 0);

        repeat (LATENCY + 4) @(posedge i_clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
